FILE: design/vst_pkg.sv
// ----------------------------------------------------------------------------
// vst_pkg: shared types and constants for velocity to speed and track
// Datapath widths, arctangent table and the beat carried along the
// rotation chain.
// ----------------------------------------------------------------------------
package vst_pkg;

  // Datapath sizes
  localparam int DW                 = 36;  // x/y width, covers 2^16 guard and gain
  localparam int ZW                 = 32;  // binary angle, 2^32 per turn
  localparam int GUARD_BITS         = 16;
  localparam int MAX_STEPS          = 24;
  localparam int ROTATION_STEPS_DEF = 16;

  // Output scaling
  localparam int              GAIN_W      = 27;
  localparam logic [26:0]     SPEED_GAIN  = 27'd79215657;  // 4*1.943844/1.6467603, Q24
  localparam int              SPEED_SHIFT = 40;
  localparam int              SPEED_W     = 19;
  localparam logic [18:0]     SPEED_MAX   = 19'd524287;
  localparam logic [ZW-1:0]   HALF_TURN   = 32'h8000_0000;

  // atan(2^-i) in 2^-32 turn units
  localparam logic [ZW-1:0] ATAN_TURNS [MAX_STEPS] = '{
    32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // One beat moving down the rotation chain
  typedef struct packed {
    logic                 vld;
    logic                 comp;   // result is a computed one
    logic                 zero;   // force track to zero
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic [ZW-1:0]        z;
  } vst_beat_t;

endpackage

FILE: design/vst_cell.sv
// ----------------------------------------------------------------------------
// vst_cell: one vectoring micro-rotation
// Rotates (x, y) toward the positive x axis by atan(2^-STEP) and
// accumulates the angle; registered, advancing on the shared enable.
// ----------------------------------------------------------------------------
module vst_cell #(
  parameter int STEP = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  vst_pkg::vst_beat_t  beat_in,
  output vst_pkg::vst_beat_t  beat_out
);
  import vst_pkg::*;

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  vst_beat_t            beat_next;

  // Rotate by the sign of y
  always_comb begin
    dx        = beat_in.y >>> STEP;
    dy        = beat_in.x >>> STEP;
    beat_next = beat_in;
    if (!beat_in.y[DW-1]) begin
      beat_next.x = beat_in.x + dx;
      beat_next.y = beat_in.y - dy;
      beat_next.z = beat_in.z + ATAN_TURNS[STEP];
    end else begin
      beat_next.x = beat_in.x - dx;
      beat_next.y = beat_in.y + dy;
      beat_next.z = beat_in.z - ATAN_TURNS[STEP];
    end
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_out.vld <= 1'b0;
    end else if (adv) begin
      beat_out.vld <= beat_next.vld;
    end
    if (adv) begin
      beat_out.comp <= beat_next.comp;
      beat_out.zero <= beat_next.zero;
      beat_out.x    <= beat_next.x;
      beat_out.y    <= beat_next.y;
      beat_out.z    <= beat_next.z;
    end
  end

endmodule

FILE: design/vst_speed.sv
// ----------------------------------------------------------------------------
// vst_speed: gain scaling and output register
// Multiplies the magnitude by the knot gain as two partial products,
// rounds, saturates, and rounds the angle to 16 bits.
// ----------------------------------------------------------------------------
module vst_speed (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  vst_pkg::vst_beat_t                beat_in,
  output logic                              out_vld,
  output logic [vst_pkg::SPEED_W-1:0]       speed,
  output logic [15:0]                       track,
  output logic                              comp
);
  import vst_pkg::*;

  localparam int XW  = 33;            // magnitude bits that can be set
  localparam int LW  = 17;            // low partial width
  localparam int HW  = XW - LW;
  localparam int SW  = XW + GAIN_W + 1;

  // Stage A registers
  logic                    a_vld;
  logic                    a_comp;
  logic [LW+GAIN_W-1:0]    p_lo;
  logic [HW+GAIN_W-1:0]    p_hi;
  logic [15:0]             a_track;

  logic [XW-1:0]           mag;
  logic [ZW-1:0]           z_rnd;
  logic [SW-1:0]           sum;
  logic [SW-SPEED_SHIFT-1:0] spd_full;

  // Clamp negative magnitude, round angle
  always_comb begin
    mag   = beat_in.x[DW-1] ? '0 : beat_in.x[XW-1:0];
    z_rnd = beat_in.z + ZW'(32'h0000_8000);
  end

  // Stage A: partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= beat_in.vld;
    end
    if (adv) begin
      a_comp  <= beat_in.comp;
      p_lo    <= (LW+GAIN_W)'(mag[LW-1:0]) * (LW+GAIN_W)'(SPEED_GAIN);
      p_hi    <= (HW+GAIN_W)'(mag[XW-1:LW]) * (HW+GAIN_W)'(SPEED_GAIN);
      a_track <= (beat_in.zero || !beat_in.comp) ? 16'd0 : z_rnd[ZW-1:16];
    end
  end

  // Stage B: sum, round, saturate
  always_comb begin
    sum      = (SW'(p_hi) << LW) + SW'(p_lo) + (SW'(1) << (SPEED_SHIFT - 1));
    spd_full = sum[SW-1:SPEED_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= a_vld;
    end
    if (adv) begin
      comp  <= a_comp;
      track <= a_track;
      if (!a_comp) begin
        speed <= '0;
      end else if (spd_full > (SW-SPEED_SHIFT)'(SPEED_MAX)) begin
        speed <= SPEED_MAX;
      end else begin
        speed <= spd_full[SPEED_W-1:0];
      end
    end
  end

endmodule

FILE: design/velocity_to_speed_and_track_core.sv
// ----------------------------------------------------------------------------
// velocity_to_speed_and_track_core: ground speed and track from velocity
// Vectoring rotation chain turning east/north velocity into speed in
// 1/16 knot and track as a 16-bit binary angle.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------
//  item     | item_valid / item_stall    | vel_east, vel_north, east_present,
//           |                            | north_present, already_known
//  result   | result_valid / result_stall| speed_knots, track_angle, computed
//
// One beat per cycle in and out while the pipeline moves; the stages are one
// input stage, one cell per rotation step (ROTATION_STEPS, capped at 24), two scaling stages.
// The whole pipeline moves on one enable; it holds only while the output
// register is full and result_stall is high, and item_stall follows that.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module velocity_to_speed_and_track_core #(
  parameter int ROTATION_STEPS = vst_pkg::ROTATION_STEPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic signed [15:0]           vel_east,
  input  logic signed [15:0]           vel_north,
  input  logic                         east_present,
  input  logic                         north_present,
  input  logic                         already_known,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [vst_pkg::SPEED_W-1:0]  speed_knots,
  output logic [15:0]                  track_angle,
  output logic                         computed
);
  import vst_pkg::*;

  localparam int NSTEP = (ROTATION_STEPS < MAX_STEPS) ? ROTATION_STEPS : MAX_STEPS;

  logic                 adv;
  logic                 comp_in;
  logic                 neg;
  logic signed [DW-1:0] xs;
  logic signed [DW-1:0] ys;
  vst_beat_t            pre_next;
  vst_beat_t            chain [NSTEP+1];

  // Pipeline moves unless the output beat is held
  assign adv        = !(result_valid && result_stall);
  assign item_stall = !adv;

  // Input stage: qualify, fold left half plane, add guard bits
  always_comb begin
    comp_in = east_present && north_present && !already_known;
    neg     = vel_north[15];
    xs      = DW'(vel_north);
    ys      = DW'(vel_east);
    if (neg) begin
      xs = -xs;
      ys = -ys;
    end
    pre_next.vld  = item_valid;
    pre_next.comp = comp_in;
    pre_next.zero = !comp_in || (vel_east == 16'sd0 && vel_north == 16'sd0);
    pre_next.x    = comp_in ? (xs <<< GUARD_BITS) : '0;
    pre_next.y    = comp_in ? (ys <<< GUARD_BITS) : '0;
    pre_next.z    = (comp_in && neg) ? HALF_TURN : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].vld <= 1'b0;
    end else if (adv) begin
      chain[0].vld <= pre_next.vld;
    end
    if (adv) begin
      chain[0].comp <= pre_next.comp;
      chain[0].zero <= pre_next.zero;
      chain[0].x    <= pre_next.x;
      chain[0].y    <= pre_next.y;
      chain[0].z    <= pre_next.z;
    end
  end

  // Rotation chain
  for (genvar g = 0; g < NSTEP; g++) begin : g_cell
    vst_cell #(
      .STEP (g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .beat_in  (chain[g]),
      .beat_out (chain[g+1])
    );
  end

  // Scaling and output register
  vst_speed u_speed (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .beat_in (chain[NSTEP]),
    .out_vld (result_valid),
    .speed   (speed_knots),
    .track   (track_angle),
    .comp    (computed)
  );

  // Checks
  a_uncomputed_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !computed |-> speed_knots == '0 && track_angle == '0)
    else $error("uncomputed result carries nonzero fields");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("input stalled without a held result");

endmodule
